// File: design/csem_pkg.sv
// Shared types and constants for the counting semaphore with wait list.
// No dependencies; the cell, the list row and the top level import it.
package csem_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int ID_W      = 4;
  localparam int AMT_W     = 32;
  localparam int KIND_W    = 3;
  localparam int DATA_W    = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANTED = 3'd0,
    KIND_REFUSED = 3'd1,
    KIND_WAITING = 3'd2,
    KIND_WOKEN   = 3'd3,
    KIND_NONE    = 3'd4
  } kind_e;

  typedef enum logic {
    OP_TAKE = 1'b0,
    OP_GIVE = 1'b1
  } opcode_e;

  // Control shared by every cell of the wait list row
  typedef struct packed {
    logic             rotate;     // every cell takes its right neighbor
    logic             compact;    // cells at or after a key hit take their neighbor
    logic [ID_W-1:0]  key_task;   // task searched for while compacting
    logic [ID_W-1:0]  ld_task;    // entry written at the load position
    logic [AMT_W-1:0] ld_amount;
  } list_ctrl_t;

endpackage

// File: design/csem_cell.sv
// One wait list entry: task id and amount, with the key-hit chain link.
// Depends on csem_pkg.
module csem_cell
  import csem_pkg::*;
(
  input  logic             clk_i,
  input  list_ctrl_t       ctrl_i,
  input  logic             occupied_i,
  input  logic             load_i,
  input  logic             hit_i,
  input  logic [ID_W-1:0]  nb_task_i,
  input  logic [AMT_W-1:0] nb_amount_i,
  output logic             hit_o,
  output logic [ID_W-1:0]  task_o,
  output logic [AMT_W-1:0] amount_o
);

  logic [ID_W-1:0]  task_q, task_d;
  logic [AMT_W-1:0] amount_q, amount_d;
  logic             shift;

  // Pass the hit on: this entry or one nearer the head matches the key
  assign hit_o = hit_i | (occupied_i & (task_q == ctrl_i.key_task));
  assign shift = ctrl_i.rotate | (ctrl_i.compact & hit_o);

  // Load wins over shift; otherwise take the neighbor or hold
  always_comb begin
    task_d   = task_q;
    amount_d = amount_q;
    if (load_i) begin
      task_d   = ctrl_i.ld_task;
      amount_d = ctrl_i.ld_amount;
    end else if (shift) begin
      task_d   = nb_task_i;
      amount_d = nb_amount_i;
    end
  end

  always_ff @(posedge clk_i) begin
    task_q   <= task_d;
    amount_q <= amount_d;
  end

  assign task_o   = task_q;
  assign amount_o = amount_q;

endmodule

// File: design/csem_list.sv
// Row of wait list cells, head at cell 0, with occupancy and load decode.
// Depends on csem_pkg and csem_cell.
module csem_list
  import csem_pkg::*;
(
  input  logic             clk_i,
  input  list_ctrl_t       ctrl_i,
  input  logic [CNT_W-1:0] total_i,
  input  logic             load_en_i,
  input  logic [CNT_W-1:0] wr_idx_i,
  output logic [ID_W-1:0]  head_task_o,
  output logic [AMT_W-1:0] head_amount_o,
  output logic             listed_o
);

  logic [MAX_TASKS-1:0]  hit;
  logic [ID_W-1:0]       cell_task   [MAX_TASKS];
  logic [AMT_W-1:0]      cell_amount [MAX_TASKS];

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    logic             occupied;
    logic             load;
    logic             hit_in;
    logic [ID_W-1:0]  nb_task;
    logic [AMT_W-1:0] nb_amount;

    assign occupied = CNT_W'(i) < total_i;
    assign load     = load_en_i & (CNT_W'(i) == wr_idx_i);

    if (i == 0) begin : g_first
      assign hit_in = 1'b0;
    end else begin : g_rest
      assign hit_in = hit[i-1];
    end

    // Last cell takes the head's data; its content is dead after a shift
    if (i == MAX_TASKS - 1) begin : g_last
      assign nb_task   = cell_task[0];
      assign nb_amount = cell_amount[0];
    end else begin : g_mid
      assign nb_task   = cell_task[i+1];
      assign nb_amount = cell_amount[i+1];
    end

    csem_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl_i),
      .occupied_i  (occupied),
      .load_i      (load),
      .hit_i       (hit_in),
      .nb_task_i   (nb_task),
      .nb_amount_i (nb_amount),
      .hit_o       (hit[i]),
      .task_o      (cell_task[i]),
      .amount_o    (cell_amount[i])
    );
  end

  assign head_task_o   = cell_task[0];
  assign head_amount_o = cell_amount[0];
  assign listed_o      = hit[MAX_TASKS-1];

endmodule

// File: design/counting_semaphore_wait_list_top.sv
// Counting semaphore top level: handshakes, count, sequencer, result register.
// Depends on csem_pkg and csem_list.
//
//  channel   direction  fields (low bit up)
//  s_axis    in         tuser: opcode; tdata: task_id[3:0], amount[35:4],
//                       immediate_only[36], timed_out[37], zero[39:38]
//  m_axis    out        tuser: kind; tlast: last; tdata: woken_task[3:0],
//                       count_after[35:4], zero[39:36]
//  cfg       in         cfg_we_i / cfg_wdata_i: initial_count, one cycle write
//
// A take is decided in the cycle it is accepted, its result is registered.
// A give adds the amount when accepted, then, for each of the N listed waiters,
// examines the head cell as the row rotates, and then registers the final result.
// The row of cells rotates one entry per cycle while the result register is free.
// Reset empties the list and clears the count; a config write does the same
// with the written value. A stalled result holds the sequencer in place.
module counting_semaphore_wait_list_top
  import csem_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [AMT_W-1:0]  cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // task_id, amount, immediate_only, timed_out
  input  logic              s_axis_tuser,   // opcode
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // woken_task, count_after
  output logic [KIND_W-1:0] m_axis_tuser,   // kind
  output logic              m_axis_tlast    // last
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [AMT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             pend_valid_q, pend_valid_d;
  logic [ID_W-1:0]  pend_task_q, pend_task_d;

  logic             out_valid_q, out_valid_d;
  kind_e            out_kind_q, out_kind_d;
  logic [ID_W-1:0]  out_task_q, out_task_d;
  logic [AMT_W-1:0] out_count_q, out_count_d;
  logic             out_last_q, out_last_d;

  logic             out_free;
  logic             in_xfer;
  opcode_e          in_op;
  logic [ID_W-1:0]  in_task;
  logic [AMT_W-1:0] in_amount;
  logic             in_imm;
  logic             in_timed;

  list_ctrl_t       lctrl;
  logic             load_en;
  logic [CNT_W-1:0] wr_idx;
  logic [ID_W-1:0]  head_task;
  logic [AMT_W-1:0] head_amount;
  logic             listed;
  logic             head_wakes;

  // Unpack the input transfer
  assign in_op     = opcode_e'(s_axis_tuser);
  assign in_task   = s_axis_tdata[ID_W-1:0];
  assign in_amount = s_axis_tdata[ID_W +: AMT_W];
  assign in_imm    = s_axis_tdata[ID_W + AMT_W];
  assign in_timed  = s_axis_tdata[ID_W + AMT_W + 1];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign head_wakes    = head_amount <= count_q;

  csem_list u_list (
    .clk_i         (clk_i),
    .ctrl_i        (lctrl),
    .total_i       (total_q),
    .load_en_i     (load_en),
    .wr_idx_i      (wr_idx),
    .head_task_o   (head_task),
    .head_amount_o (head_amount),
    .listed_o      (listed)
  );

  // Sequencer: decide takes, start and step gives, drive the list row
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    total_d      = total_q;
    rem_d        = rem_q;
    pend_valid_d = pend_valid_q;
    pend_task_d  = pend_task_q;

    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_task_d  = out_task_q;
    out_count_d = out_count_q;
    out_last_d  = out_last_q;

    lctrl.rotate    = 1'b0;
    lctrl.compact   = 1'b0;
    lctrl.key_task  = in_task;
    lctrl.ld_task   = in_task;
    lctrl.ld_amount = in_amount;
    load_en         = 1'b0;
    wr_idx          = total_q - CNT_W'(listed);

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_op == OP_GIVE) begin
            count_d = count_q + in_amount;
            rem_d   = total_q;
            state_d = ST_SCAN;
          end else begin
            out_valid_d = 1'b1;
            out_task_d  = in_task;
            out_last_d  = 1'b1;
            out_count_d = count_q;
            if (count_q >= in_amount) begin
              count_d     = count_q - in_amount;
              out_count_d = count_q - in_amount;
              out_kind_d  = KIND_GRANTED;
            end else if (in_imm || in_timed) begin
              out_kind_d = KIND_REFUSED;
            end else if (!listed && (total_q == CNT_W'(MAX_TASKS))) begin
              out_kind_d = KIND_REFUSED;
            end else begin
              // Drop an old entry of this task and append at the tail
              lctrl.compact = 1'b1;
              load_en       = 1'b1;
              total_d       = wr_idx + CNT_W'(1);
              out_kind_d    = KIND_WAITING;
            end
          end
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          if (rem_q != '0) begin
            // Examine the head, rotate, and put a kept entry back at the tail
            lctrl.rotate    = 1'b1;
            lctrl.ld_task   = head_task;
            lctrl.ld_amount = head_amount;
            wr_idx          = total_q - CNT_W'(1);
            rem_d           = rem_q - CNT_W'(1);
            if (head_wakes) begin
              total_d      = total_q - CNT_W'(1);
              pend_valid_d = 1'b1;
              pend_task_d  = head_task;
              if (pend_valid_q) begin
                out_valid_d = 1'b1;
                out_kind_d  = KIND_WOKEN;
                out_task_d  = pend_task_q;
                out_count_d = count_q;
                out_last_d  = 1'b0;
              end
            end else begin
              load_en = 1'b1;
            end
          end else begin
            // Close the give with the held waiter or a no-wake result
            out_valid_d  = 1'b1;
            out_kind_d   = pend_valid_q ? KIND_WOKEN : KIND_NONE;
            out_task_d   = pend_valid_q ? pend_task_q : '0;
            out_count_d  = count_q;
            out_last_d   = 1'b1;
            pend_valid_d = 1'b0;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Load the count and empty the list on a register write
    if (cfg_we_i) begin
      count_d = cfg_wdata_i;
      total_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      total_q      <= '0;
      rem_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      total_q      <= total_d;
      rem_q        <= rem_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk_i) begin
    pend_task_q <= pend_task_d;
    out_kind_q  <= out_kind_d;
    out_task_q  <= out_task_d;
    out_count_q <= out_count_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(DATA_W - ID_W - AMT_W){1'b0}}, out_count_q, out_task_q};

`ifndef NO_ASSERTIONS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(MAX_TASKS))
    else $error("wait list fill exceeds its size");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rem_q <= total_q))
    else $error("scan remainder exceeds list fill");

  a_give_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (in_op == OP_GIVE)) |=> (state_q == ST_SCAN))
    else $error("give did not start a scan");

  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q == ST_SCAN))
    else $error("held waiter outside a scan");

  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != KIND_WOKEN)) |-> m_axis_tlast)
    else $error("single result not marked last");
`endif

endmodule
